@@ rtl/core/ais_pkg.sv @@
// shared types, constants and register map of the affine inlier scorer
// no dependencies

package ais_pkg;

    localparam int COEF_W   = 32;
    localparam int PT_W     = 16;
    localparam int LIMIT_W  = 16;
    localparam int TALLY_W  = 13;
    localparam int SUM_W    = 29;
    localparam int PROD_W   = COEF_W + PT_W + 1;
    localparam int PSUM_W   = PROD_W + 1;
    localparam int TRANS_W  = COEF_W + 6;
    localparam int DIFF_W   = PSUM_W + 2;
    localparam int FRAC_SH  = 16;
    localparam int ADDR_W   = 5;
    localparam int DATA_W   = 32;
    localparam int STEP_W   = $clog2(SUM_W);
    localparam int QUEUE_DEPTH_DEF = 8;

    localparam logic [TALLY_W-1:0] TALLY_TOP = {TALLY_W{1'b1}};

    localparam logic [COEF_W-1:0]  COEF_ONE   = 32'h0001_0000;
    localparam logic [COEF_W-1:0]  COEF_ZERO  = 32'h0000_0000;
    localparam logic [LIMIT_W-1:0] LIMIT_RST  = 16'd48;

    typedef enum logic [2:0] {
        REG_COEF_A       = 3'd0,
        REG_COEF_B       = 3'd1,
        REG_COEF_C       = 3'd2,
        REG_COEF_D       = 3'd3,
        REG_COEF_E       = 3'd4,
        REG_COEF_F       = 3'd5,
        REG_INLIER_LIMIT = 3'd6
    } ais_reg_idx_t;

    typedef struct packed {
        logic [COEF_W-1:0]  coef_a;
        logic [COEF_W-1:0]  coef_b;
        logic [COEF_W-1:0]  coef_c;
        logic [COEF_W-1:0]  coef_d;
        logic [COEF_W-1:0]  coef_e;
        logic [COEF_W-1:0]  coef_f;
        logic [LIMIT_W-1:0] inlier_limit;
    } ais_cfg_t;

    typedef struct packed {
        logic [PT_W-1:0] resid_x;
        logic [PT_W-1:0] resid_y;
        logic            is_inlier;
        logic            last_pair;
    } ais_entry_t;

    typedef enum logic [1:0] {
        BK_IDLE = 2'd0,
        BK_DIV  = 2'd1,
        BK_OUT  = 2'd2
    } ais_back_state_t;

endpackage

@@ rtl/core/ais_front.sv @@
// front end: three-stage affine map, residual and inlier classification
// depends on ais_pkg

module ais_front import ais_pkg::*; (
    input  logic               aclk,
    input  logic               aresetn,
    input  ais_cfg_t           cfg,
    input  logic               in_take,
    input  logic [PT_W-1:0]    src_x,
    input  logic [PT_W-1:0]    src_y,
    input  logic [PT_W-1:0]    dst_x,
    input  logic [PT_W-1:0]    dst_y,
    input  logic               last_pair,
    output logic               out_valid,
    output ais_entry_t         out_entry,
    output logic [1:0]         inflight
);

    function automatic logic [PT_W-1:0] abs_sat(input logic [DIFF_W-1:0] d);
        logic [DIFF_W-1:0] mag;
        begin
            mag = d[DIFF_W-1] ? (~d + {{(DIFF_W-1){1'b0}}, 1'b1}) : d;
            abs_sat = (|mag[DIFF_W-1:FRAC_SH+PT_W]) ? {PT_W{1'b1}}
                                                    : mag[FRAC_SH+PT_W-1:FRAC_SH];
        end
    endfunction

    logic                     v1_reg, v2_reg, v3_reg;
    logic                     last1_reg, last2_reg, last3_reg;
    logic signed [PROD_W-1:0] pax_reg, pbx_reg, pdy_reg, pey_reg;
    logic [TRANS_W-1:0]       tx1_reg, ty1_reg, tx2_reg, ty2_reg;
    logic [PSUM_W-1:0]        sx2_reg, sy2_reg;
    logic [DIFF_W-1:0]        dfx_reg, dfy_reg;
    logic [TRANS_W-1:0]       tx_next, ty_next;
    logic [PT_W-1:0]          rx, ry;

    assign tx_next = {{2{cfg.coef_c[COEF_W-1]}}, cfg.coef_c, 4'b0}
                   - {6'b0, dst_x, 16'b0};
    assign ty_next = {{2{cfg.coef_f[COEF_W-1]}}, cfg.coef_f, 4'b0}
                   - {6'b0, dst_y, 16'b0};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else begin
            v1_reg <= in_take;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        pax_reg   <= $signed(cfg.coef_a) * $signed({1'b0, src_x});
        pbx_reg   <= $signed(cfg.coef_b) * $signed({1'b0, src_y});
        pdy_reg   <= $signed(cfg.coef_d) * $signed({1'b0, src_x});
        pey_reg   <= $signed(cfg.coef_e) * $signed({1'b0, src_y});
        tx1_reg   <= tx_next;
        ty1_reg   <= ty_next;
        last1_reg <= last_pair;

        sx2_reg   <= {pax_reg[PROD_W-1], pax_reg} + {pbx_reg[PROD_W-1], pbx_reg};
        sy2_reg   <= {pdy_reg[PROD_W-1], pdy_reg} + {pey_reg[PROD_W-1], pey_reg};
        tx2_reg   <= tx1_reg;
        ty2_reg   <= ty1_reg;
        last2_reg <= last1_reg;

        dfx_reg   <= {{(DIFF_W-PSUM_W){sx2_reg[PSUM_W-1]}}, sx2_reg}
                   + {{(DIFF_W-TRANS_W){tx2_reg[TRANS_W-1]}}, tx2_reg};
        dfy_reg   <= {{(DIFF_W-PSUM_W){sy2_reg[PSUM_W-1]}}, sy2_reg}
                   + {{(DIFF_W-TRANS_W){ty2_reg[TRANS_W-1]}}, ty2_reg};
        last3_reg <= last2_reg;
    end

    assign rx = abs_sat(dfx_reg);
    assign ry = abs_sat(dfy_reg);

    assign out_valid           = v3_reg;
    assign out_entry.resid_x   = rx;
    assign out_entry.resid_y   = ry;
    assign out_entry.is_inlier = (rx < cfg.inlier_limit) && (ry < cfg.inlier_limit);
    assign out_entry.last_pair = last3_reg;

    assign inflight = {1'b0, v1_reg} + {1'b0, v2_reg} + {1'b0, v3_reg};

endmodule

@@ rtl/core/ais_queue.sv @@
// circular item queue between front and back end
// depends on ais_pkg

module ais_queue import ais_pkg::*; #(
    parameter int DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         push,
    input  ais_entry_t                   push_entry,
    input  logic                         pop,
    output logic                         head_valid,
    output ais_entry_t                   head_entry,
    output logic [$clog2(DEPTH+1)-1:0]   count
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);

    ais_entry_t       buf_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            buf_reg[wr_ptr_reg] <= push_entry;
        end
    end

    assign head_valid = (count_reg != '0);
    assign head_entry = buf_reg[rd_ptr_reg];
    assign count      = count_reg;

endmodule

@@ rtl/core/ais_back.sv @@
// back end: inlier accumulation, serial mean divider and result register
// depends on ais_pkg

module ais_back import ais_pkg::*; (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               q_valid,
    input  ais_entry_t         q_entry,
    output logic               q_pop,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [PT_W-1:0]    m_resid_x,
    output logic [PT_W-1:0]    m_resid_y,
    output logic               m_is_inlier,
    output logic [TALLY_W-1:0] m_total_inliers,
    output logic [PT_W-1:0]    m_mean_resid_x,
    output logic [PT_W-1:0]    m_mean_resid_y,
    output logic               m_set_done
);

    localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(SUM_W - 1);

    ais_back_state_t state_reg, state_next;

    logic [TALLY_W-1:0] tally_reg, tally_next;
    logic [SUM_W-1:0]   sumx_reg, sumx_next, sumy_reg, sumy_next;
    logic [SUM_W-1:0]   dvx_reg, dvx_next, dvy_reg, dvy_next;
    logic [TALLY_W-1:0] remx_reg, remx_next, remy_reg, remy_next;
    logic [TALLY_W-1:0] dsor_reg, dsor_next;
    logic [STEP_W-1:0]  step_reg, step_next;
    logic [PT_W-1:0]    rx_reg, rx_next, ry_reg, ry_next;
    logic [PT_W-1:0]    meanx_reg, meanx_next, meany_reg, meany_next;
    logic [TALLY_W-1:0] tot_reg, tot_next;
    logic               inl_reg, inl_next, done_reg, done_next;

    logic               take;
    logic [TALLY_W-1:0] tally_acc;
    logic [SUM_W-1:0]   sumx_acc, sumy_acc;
    logic [TALLY_W:0]   trial_x, trial_y, diff_x, diff_y;
    logic               ge_x, ge_y;
    logic [SUM_W-1:0]   quo_x, quo_y;

    // accumulation of the popped item
    assign take      = q_entry.is_inlier && (tally_reg != TALLY_TOP);
    assign tally_acc = tally_reg + {{(TALLY_W-1){1'b0}}, take};
    assign sumx_acc  = take ? sumx_reg + {{(SUM_W-PT_W){1'b0}}, q_entry.resid_x} : sumx_reg;
    assign sumy_acc  = take ? sumy_reg + {{(SUM_W-PT_W){1'b0}}, q_entry.resid_y} : sumy_reg;

    // one restoring division step per lane
    assign trial_x = {remx_reg, dvx_reg[SUM_W-1]};
    assign trial_y = {remy_reg, dvy_reg[SUM_W-1]};
    assign diff_x  = trial_x - {1'b0, dsor_reg};
    assign diff_y  = trial_y - {1'b0, dsor_reg};
    assign ge_x    = (trial_x >= {1'b0, dsor_reg});
    assign ge_y    = (trial_y >= {1'b0, dsor_reg});
    assign quo_x   = {dvx_reg[SUM_W-2:0], ge_x};
    assign quo_y   = {dvy_reg[SUM_W-2:0], ge_y};

    // handshake outputs
    always_comb begin
        q_pop   = 1'b0;
        m_valid = 1'b0;
        case (state_reg)
            BK_IDLE: q_pop = q_valid;
            BK_DIV:  q_pop = 1'b0;
            BK_OUT: begin
                m_valid = 1'b1;
                q_pop   = q_valid && m_ready;
            end
            default: q_pop = 1'b0;
        endcase
    end

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            BK_IDLE, BK_OUT: begin
                if (q_pop) begin
                    state_next = (q_entry.last_pair && tally_acc != '0) ? BK_DIV : BK_OUT;
                end else if (state_reg == BK_OUT && m_ready) begin
                    state_next = BK_IDLE;
                end
            end
            BK_DIV: begin
                if (step_reg == STEP_LAST) begin
                    state_next = BK_OUT;
                end
            end
            default: state_next = BK_IDLE;
        endcase
    end

    // datapath next values
    always_comb begin
        tally_next = tally_reg;
        sumx_next  = sumx_reg;
        sumy_next  = sumy_reg;
        dvx_next   = dvx_reg;
        dvy_next   = dvy_reg;
        remx_next  = remx_reg;
        remy_next  = remy_reg;
        dsor_next  = dsor_reg;
        step_next  = step_reg;
        rx_next    = rx_reg;
        ry_next    = ry_reg;
        inl_next   = inl_reg;
        done_next  = done_reg;
        tot_next   = tot_reg;
        meanx_next = meanx_reg;
        meany_next = meany_reg;
        if (q_pop) begin
            rx_next    = q_entry.resid_x;
            ry_next    = q_entry.resid_y;
            inl_next   = q_entry.is_inlier;
            done_next  = q_entry.last_pair;
            meanx_next = '0;
            meany_next = '0;
            dvx_next   = sumx_acc;
            dvy_next   = sumy_acc;
            remx_next  = '0;
            remy_next  = '0;
            dsor_next  = tally_acc;
            step_next  = '0;
            if (q_entry.last_pair) begin
                tot_next   = tally_acc;
                tally_next = '0;
                sumx_next  = '0;
                sumy_next  = '0;
            end else begin
                tot_next   = '0;
                tally_next = tally_acc;
                sumx_next  = sumx_acc;
                sumy_next  = sumy_acc;
            end
        end else if (state_reg == BK_DIV) begin
            dvx_next  = quo_x;
            dvy_next  = quo_y;
            remx_next = ge_x ? diff_x[TALLY_W-1:0] : trial_x[TALLY_W-1:0];
            remy_next = ge_y ? diff_y[TALLY_W-1:0] : trial_y[TALLY_W-1:0];
            step_next = step_reg + 1'b1;
            if (step_reg == STEP_LAST) begin
                meanx_next = quo_x[PT_W-1:0];
                meany_next = quo_y[PT_W-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= BK_IDLE;
            tally_reg <= '0;
            sumx_reg  <= '0;
            sumy_reg  <= '0;
            step_reg  <= '0;
        end else begin
            state_reg <= state_next;
            tally_reg <= tally_next;
            sumx_reg  <= sumx_next;
            sumy_reg  <= sumy_next;
            step_reg  <= step_next;
        end
    end

    always_ff @(posedge aclk) begin
        dvx_reg   <= dvx_next;
        dvy_reg   <= dvy_next;
        remx_reg  <= remx_next;
        remy_reg  <= remy_next;
        dsor_reg  <= dsor_next;
        rx_reg    <= rx_next;
        ry_reg    <= ry_next;
        inl_reg   <= inl_next;
        done_reg  <= done_next;
        tot_reg   <= tot_next;
        meanx_reg <= meanx_next;
        meany_reg <= meany_next;
    end

    assign m_resid_x       = rx_reg;
    assign m_resid_y       = ry_reg;
    assign m_is_inlier     = inl_reg;
    assign m_total_inliers = tot_reg;
    assign m_mean_resid_x  = meanx_reg;
    assign m_mean_resid_y  = meany_reg;
    assign m_set_done      = done_reg;

endmodule

@@ rtl/core/affine_inlier_scorer_top.sv @@
// Affine inlier scorer: maps each source point of a pair through the configured 2x3 affine
// matrix and gives absolute residuals against the destination point, an inlier flag and, on
// the last pair of a set, the inlier count and mean residuals. One item is accepted per cycle
// while the queue has room; its result passes the front pipeline and the queue, is registered in
// the back end and is held there while the result side stalls. A last pair of a set
// with at least one inlier holds the back end while the serial mean divider
// forms one quotient bit per cycle; the front end keeps accepting items into the queue meanwhile.
// Depends on ais_pkg, ais_front, ais_queue and ais_back.

module affine_inlier_scorer_top import ais_pkg::*; #(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [ADDR_W-1:0]  paddr,
    input  logic [DATA_W-1:0]  pwdata,
    output logic [DATA_W-1:0]  prdata,
    output logic               pready,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [PT_W-1:0]    s_src_x,
    input  logic [PT_W-1:0]    s_src_y,
    input  logic [PT_W-1:0]    s_dst_x,
    input  logic [PT_W-1:0]    s_dst_y,
    input  logic               s_last_pair,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [PT_W-1:0]    m_resid_x,
    output logic [PT_W-1:0]    m_resid_y,
    output logic               m_is_inlier,
    output logic [TALLY_W-1:0] m_total_inliers,
    output logic [PT_W-1:0]    m_mean_resid_x,
    output logic [PT_W-1:0]    m_mean_resid_y,
    output logic               m_set_done
);

    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    ais_cfg_t           cfg_reg;
    ais_reg_idx_t       reg_idx;
    logic               cfg_wr;
    logic               s_take;
    logic               f_valid;
    ais_entry_t         f_entry;
    logic [1:0]         inflight;
    logic               q_valid, q_pop;
    ais_entry_t         q_entry;
    logic [CNT_W-1:0]   q_count;
    logic [CNT_W+1:0]   occupancy;

    assign pready  = 1'b1;
    assign reg_idx = ais_reg_idx_t'(paddr[ADDR_W-1:2]);
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.coef_a       <= COEF_ONE;
            cfg_reg.coef_b       <= COEF_ZERO;
            cfg_reg.coef_c       <= COEF_ZERO;
            cfg_reg.coef_d       <= COEF_ZERO;
            cfg_reg.coef_e       <= COEF_ONE;
            cfg_reg.coef_f       <= COEF_ZERO;
            cfg_reg.inlier_limit <= LIMIT_RST;
        end else if (cfg_wr) begin
            case (reg_idx)
                REG_COEF_A:       cfg_reg.coef_a       <= pwdata;
                REG_COEF_B:       cfg_reg.coef_b       <= pwdata;
                REG_COEF_C:       cfg_reg.coef_c       <= pwdata;
                REG_COEF_D:       cfg_reg.coef_d       <= pwdata;
                REG_COEF_E:       cfg_reg.coef_e       <= pwdata;
                REG_COEF_F:       cfg_reg.coef_f       <= pwdata;
                REG_INLIER_LIMIT: cfg_reg.inlier_limit <= pwdata[LIMIT_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_COEF_A:       prdata = cfg_reg.coef_a;
            REG_COEF_B:       prdata = cfg_reg.coef_b;
            REG_COEF_C:       prdata = cfg_reg.coef_c;
            REG_COEF_D:       prdata = cfg_reg.coef_d;
            REG_COEF_E:       prdata = cfg_reg.coef_e;
            REG_COEF_F:       prdata = cfg_reg.coef_f;
            REG_INLIER_LIMIT: prdata = {{(DATA_W-LIMIT_W){1'b0}}, cfg_reg.inlier_limit};
            default:          prdata = '0;
        endcase
    end

    // room for every item in the front pipeline plus the new one
    assign occupancy = {2'b00, q_count} + {{CNT_W{1'b0}}, inflight};
    assign s_ready   = (occupancy < (CNT_W+2)'(QUEUE_DEPTH));
    assign s_take    = s_valid && s_ready;

    ais_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg_reg),
        .in_take   (s_take),
        .src_x     (s_src_x),
        .src_y     (s_src_y),
        .dst_x     (s_dst_x),
        .dst_y     (s_dst_y),
        .last_pair (s_last_pair),
        .out_valid (f_valid),
        .out_entry (f_entry),
        .inflight  (inflight)
    );

    ais_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (f_valid),
        .push_entry (f_entry),
        .pop        (q_pop),
        .head_valid (q_valid),
        .head_entry (q_entry),
        .count      (q_count)
    );

    ais_back u_back (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .q_valid         (q_valid),
        .q_entry         (q_entry),
        .q_pop           (q_pop),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_resid_x       (m_resid_x),
        .m_resid_y       (m_resid_y),
        .m_is_inlier     (m_is_inlier),
        .m_total_inliers (m_total_inliers),
        .m_mean_resid_x  (m_mean_resid_x),
        .m_mean_resid_y  (m_mean_resid_y),
        .m_set_done      (m_set_done)
    );

endmodule

@@ tb/sv/ais_tb_pkg.sv @@
// scoreboard for the affine inlier scorer testbench: predicts residuals, flags and set means
// depends on ais_pkg
`timescale 1ns / 100ps

package ais_tb_pkg;
    import ais_pkg::*;

    // index that maps to no register
    localparam int REG_UNMAPPED = 7;

    typedef struct packed {
        logic [PT_W-1:0]    resid_x;
        logic [PT_W-1:0]    resid_y;
        logic               is_inlier;
        logic [TALLY_W-1:0] total_inliers;
        logic [PT_W-1:0]    mean_resid_x;
        logic [PT_W-1:0]    mean_resid_y;
        logic               set_done;
    } pair_score_t;

    class ais_inlier_board;
        logic signed [COEF_W-1:0] coef [6];
        logic [LIMIT_W-1:0]       limit;
        logic [TALLY_W-1:0]       tally;
        logic [SUM_W-1:0]         sum_x;
        logic [SUM_W-1:0]         sum_y;
        pair_score_t              score_q [$];
        int                       mismatches;

        function new();
            coef[REG_COEF_A] = COEF_ONE;
            coef[REG_COEF_B] = COEF_ZERO;
            coef[REG_COEF_C] = COEF_ZERO;
            coef[REG_COEF_D] = COEF_ZERO;
            coef[REG_COEF_E] = COEF_ONE;
            coef[REG_COEF_F] = COEF_ZERO;
            limit = LIMIT_RST;
            tally = '0;
            sum_x = '0;
            sum_y = '0;
            mismatches = 0;
        endfunction

        function void write_reg(int idx, logic [DATA_W-1:0] value);
            if (idx >= REG_COEF_A && idx <= REG_COEF_F)
                coef[idx] = value;
            else if (idx == REG_INLIER_LIMIT)
                limit = value[LIMIT_W-1:0];
        endfunction

        // mapped coordinate in Q.16, row 0 is x and row 1 is y
        function longint project(int row, logic [PT_W-1:0] sx, logic [PT_W-1:0] sy);
            return longint'(coef[3*row]) * longint'(sx)
                 + longint'(coef[3*row+1]) * longint'(sy)
                 + longint'(coef[3*row+2]) * 16;
        endfunction

        function logic [PT_W-1:0] residual_of(int row, logic [PT_W-1:0] sx,
                                              logic [PT_W-1:0] sy, logic [PT_W-1:0] dst);
            longint d;
            d = project(row, sx, sy) - (longint'(dst) <<< FRAC_SH);
            if (d < 0)
                d = -d;
            d = d >>> FRAC_SH;
            return (d > 65535) ? '1 : d[PT_W-1:0];
        endfunction

        function void note_pair(logic [PT_W-1:0] sx, logic [PT_W-1:0] sy,
                                logic [PT_W-1:0] dx, logic [PT_W-1:0] dy, logic last);
            pair_score_t s;
            logic [SUM_W-1:0] q;
            s = '0;
            s.resid_x = residual_of(0, sx, sy, dx);
            s.resid_y = residual_of(1, sx, sy, dy);
            s.is_inlier = (s.resid_x < limit) && (s.resid_y < limit);
            s.set_done = last;
            if (s.is_inlier && tally != TALLY_TOP) begin
                tally = tally + 1'b1;
                sum_x = sum_x + s.resid_x;
                sum_y = sum_y + s.resid_y;
            end
            if (last) begin
                s.total_inliers = tally;
                if (tally != 0) begin
                    q = sum_x / SUM_W'(tally);
                    s.mean_resid_x = q[PT_W-1:0];
                    q = sum_y / SUM_W'(tally);
                    s.mean_resid_y = q[PT_W-1:0];
                end
                tally = '0;
                sum_x = '0;
                sum_y = '0;
            end
            score_q.insert(score_q.size(), s);
        endfunction

        function string show(pair_score_t s);
            return $sformatf("rx=%0d ry=%0d inl=%0d tot=%0d mx=%0d my=%0d done=%0d",
                             s.resid_x, s.resid_y, s.is_inlier, s.total_inliers,
                             s.mean_resid_x, s.mean_resid_y, s.set_done);
        endfunction

        function void check_result(pair_score_t got);
            pair_score_t want;
            if (score_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: %s", show(got));
                return;
            end
            want = score_q.pop_front();
            if (got !== want) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch: expected %s, got %s", show(want), show(got));
            end
        endfunction

        function int pending();
            return score_q.size();
        endfunction
    endclass

endpackage

@@ tb/sv/affine_inlier_scorer_top_tb.sv @@
// testbench top for the affine inlier scorer: directed and random point pair sets with
// apb register writes between phases, results checked against ais_inlier_board
// depends on ais_pkg, ais_tb_pkg and affine_inlier_scorer_top
`timescale 1ns / 100ps

module affine_inlier_scorer_top_tb;
    import ais_pkg::*;
    import ais_tb_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int PHASE_ITEMS    = 250;

    logic               aclk = 1'b0;
    logic               aresetn;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [ADDR_W-1:0]  paddr;
    logic [DATA_W-1:0]  pwdata;
    logic [DATA_W-1:0]  prdata;
    logic               pready;
    logic               s_valid;
    logic               s_ready;
    logic [PT_W-1:0]    s_src_x;
    logic [PT_W-1:0]    s_src_y;
    logic [PT_W-1:0]    s_dst_x;
    logic [PT_W-1:0]    s_dst_y;
    logic               s_last_pair;
    logic               m_valid;
    logic               m_ready;
    logic [PT_W-1:0]    m_resid_x;
    logic [PT_W-1:0]    m_resid_y;
    logic               m_is_inlier;
    logic [TALLY_W-1:0] m_total_inliers;
    logic [PT_W-1:0]    m_mean_resid_x;
    logic [PT_W-1:0]    m_mean_resid_y;
    logic               m_set_done;

    ais_inlier_board board = new();
    bit quiet = 1'b0;
    int src_gap_pct = 10;
    int sink_stall_pct = 25;
    int stall_cycles = 0;

    affine_inlier_scorer_top dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_src_x         (s_src_x),
        .s_src_y         (s_src_y),
        .s_dst_x         (s_dst_x),
        .s_dst_y         (s_dst_y),
        .s_last_pair     (s_last_pair),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_resid_x       (m_resid_x),
        .m_resid_y       (m_resid_y),
        .m_is_inlier     (m_is_inlier),
        .m_total_inliers (m_total_inliers),
        .m_mean_resid_x  (m_mean_resid_x),
        .m_mean_resid_y  (m_mean_resid_y),
        .m_set_done      (m_set_done)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    task automatic write_reg(int idx, logic [DATA_W-1:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= ADDR_W'(idx * 4);
        pwdata <= value;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        board.write_reg(idx, value);
    endtask

    task automatic send_pair(logic [PT_W-1:0] sx, logic [PT_W-1:0] sy,
                             logic [PT_W-1:0] dx, logic [PT_W-1:0] dy, logic last);
        if (!quiet && $urandom_range(0, 99) < src_gap_pct) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_src_x <= sx;
        s_src_y <= sy;
        s_dst_x <= dx;
        s_dst_y <= dy;
        s_last_pair <= last;
        do @(posedge aclk); while (!s_ready);
        board.note_pair(sx, sy, dx, dy, last);
    endtask

    // wait until every result is back, then let the design sit idle
    task automatic settle();
        s_valid <= 1'b0;
        while (board.pending() != 0)
            @(posedge aclk);
        repeat (40) @(posedge aclk);
    endtask

    function automatic int jitter(int m);
        return int'($urandom_range(0, 2 * m)) - m;
    endfunction

    function automatic logic [PT_W-1:0] edge_value();
        case ($urandom_range(0, 2))
            0: return '0;
            1: return '1;
            default: return PT_W'($urandom);
        endcase
    endfunction

    // destination close to the mapped point, clamped to the coordinate range
    function automatic logic [PT_W-1:0] near_dst(int row, logic [PT_W-1:0] sx,
                                                 logic [PT_W-1:0] sy);
        longint q;
        int span;
        span = int'(board.limit) * 2 + 2;
        if (span > 2000)
            span = 2000;
        q = (board.project(row, sx, sy) >>> FRAC_SH)
          + longint'($urandom_range(0, 2 * span)) - span;
        if (q < 0)
            q = 0;
        if (q > 65535)
            q = 65535;
        return q[PT_W-1:0];
    endfunction

    task automatic send_random(logic last);
        logic [PT_W-1:0] sx, sy, dx, dy;
        int kind;
        sx = PT_W'($urandom);
        sy = PT_W'($urandom);
        if ($urandom_range(0, 3) == 0) begin
            sx = PT_W'($urandom_range(0, 4095));
            sy = PT_W'($urandom_range(0, 4095));
        end
        kind = $urandom_range(0, 99);
        if (kind < 65) begin
            dx = near_dst(0, sx, sy);
            dy = near_dst(1, sx, sy);
            if (kind < 6)
                dx = PT_W'($urandom);
            else if (kind < 12)
                dy = PT_W'($urandom);
        end else if (kind < 85) begin
            dx = PT_W'($urandom);
            dy = PT_W'($urandom);
        end else begin
            sx = edge_value();
            sy = edge_value();
            dx = edge_value();
            dy = edge_value();
        end
        send_pair(sx, sy, dx, dy, last);
    endtask

    task automatic pick_config(int mode);
        case (mode)
            0: begin
                write_reg(REG_COEF_A, 65536 + jitter(4096));
                write_reg(REG_COEF_B, jitter(4096));
                write_reg(REG_COEF_C, jitter(64 << 16));
                write_reg(REG_COEF_D, jitter(4096));
                write_reg(REG_COEF_E, 65536 + jitter(4096));
                write_reg(REG_COEF_F, jitter(64 << 16));
                write_reg(REG_INLIER_LIMIT, $urandom_range(8, 400));
            end
            1: begin
                write_reg(REG_COEF_A, jitter(3 << 16));
                write_reg(REG_COEF_B, jitter(3 << 16));
                write_reg(REG_COEF_C, jitter(4000 << 16));
                write_reg(REG_COEF_D, jitter(3 << 16));
                write_reg(REG_COEF_E, jitter(3 << 16));
                write_reg(REG_COEF_F, jitter(4000 << 16));
                write_reg(REG_INLIER_LIMIT, $urandom_range(1, 2000));
            end
            default: begin
                write_reg(REG_COEF_A, $urandom);
                write_reg(REG_COEF_B, $urandom);
                write_reg(REG_COEF_C, $urandom);
                write_reg(REG_COEF_D, $urandom);
                write_reg(REG_COEF_E, $urandom);
                write_reg(REG_COEF_F, $urandom);
                write_reg(REG_INLIER_LIMIT, $urandom_range(0, 65535));
            end
        endcase
    endtask

    task automatic run_sets(int count);
        int sent;
        int n;
        sent = 0;
        while (sent < count) begin
            n = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 3) : $urandom_range(4, 60);
            for (int i = 0; i < n; i++)
                send_random(i == n - 1);
            sent += n;
        end
    endtask

    // result sink with random stall bursts
    initial begin
        m_ready <= 1'b0;
        @(posedge aclk);
        forever begin
            if (!quiet && $urandom_range(0, 99) < sink_stall_pct) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 18)) @(posedge aclk);
            end else begin
                m_ready <= 1'b1;
                repeat ($urandom_range(1, 30)) @(posedge aclk);
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            board.check_result('{m_resid_x, m_resid_y, m_is_inlier, m_total_inliers,
                                 m_mean_resid_x, m_mean_resid_y, m_set_done});
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || psel)
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    initial begin
        aresetn <= 1'b0;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= '0;
        pwdata <= '0;
        s_valid <= 1'b0;
        s_src_x <= '0;
        s_src_y <= '0;
        s_dst_x <= '0;
        s_dst_y <= '0;
        s_last_pair <= 1'b0;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset config: identity map, limit of 48 pixels
        send_pair(16'd0, 16'd0, 16'd0, 16'd0, 1'b0);
        send_pair(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0);
        send_pair(16'd100, 16'd200, 16'd147, 16'd248, 1'b0);
        send_pair(16'd100, 16'd200, 16'd147, 16'd247, 1'b0);
        send_pair(16'd100, 16'd200, 16'd148, 16'd200, 1'b0);
        send_pair(16'd0, 16'd0, 16'hFFFF, 16'hFFFF, 1'b1);
        send_pair(16'd500, 16'd500, 16'd0, 16'd0, 1'b1);
        send_pair(16'hFFFF, 16'd0, 16'd0, 16'hFFFF, 1'b0);
        send_pair(16'd0, 16'hFFFF, 16'hFFFF, 16'd0, 1'b1);
        settle();

        // zero limit rejects everything
        write_reg(REG_INLIER_LIMIT, 0);
        send_pair(16'd0, 16'd0, 16'd0, 16'd0, 1'b0);
        send_pair(16'd7, 16'd7, 16'd7, 16'd7, 1'b1);
        settle();

        // extreme coefficients drive the residuals into saturation
        write_reg(REG_COEF_A, 32'h7FFF_FFFF);
        write_reg(REG_COEF_B, 32'h7FFF_FFFF);
        write_reg(REG_COEF_C, 32'h7FFF_FFFF);
        write_reg(REG_COEF_D, 32'h8000_0000);
        write_reg(REG_COEF_E, 32'h8000_0000);
        write_reg(REG_COEF_F, 32'h8000_0000);
        write_reg(REG_INLIER_LIMIT, 32'h0000_FFFF);
        write_reg(REG_UNMAPPED, 32'h0000_0001);
        send_pair(16'hFFFF, 16'hFFFF, 16'd0, 16'd0, 1'b0);
        send_pair(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0);
        send_pair(16'd0, 16'd0, 16'd0, 16'd0, 1'b1);
        settle();

        for (int ph = 0; ph < 8; ph++) begin
            src_gap_pct = (ph % 3 == 0) ? 0 : (ph % 3 == 1) ? 10 : 35;
            sink_stall_pct = (ph % 3 == 2) ? 0 : (ph % 3 == 0) ? 15 : 40;
            if (ph == 7)
                quiet = 1'b1;
            pick_config((ph == 7) ? 0 : ph % 3);
            run_sets(PHASE_ITEMS);
            settle();
        end

        repeat (20) @(posedge aclk);
        if (board.mismatches == 0 && board.pending() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
